// ===== rtl/fsrq_pkg.sv =====
// ----------------------------------------------------------------------------
// fsrq_pkg: shared types and constants for the fair share run queue
// Command codes, status codes, field widths and the command queue entry.
// ----------------------------------------------------------------------------
package fsrq_pkg;

   localparam int MaxTasks = 32;
   localparam int SlotW    = $clog2(MaxTasks);
   localparam int CntW     = $clog2(MaxTasks + 1);
   localparam int PidW     = 16;
   localparam int VrW      = 64;
   localparam int WgtW     = 20;
   localparam int SumW     = 26;
   localparam int NiceW    = 6;
   localparam int ElapW    = 32;
   localparam int NormW    = 16;
   localparam int LatW     = 32;
   localparam int FifoDepth = 2;

   localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};

   typedef enum logic [2:0] {
      CMD_ENQ   = 3'd0,
      CMD_DEQ   = 3'd1,
      CMD_PICK  = 3'd2,
      CMD_TICK  = 3'd3,
      CMD_SLICE = 3'd4,
      CMD_NICE  = 3'd5,
      CMD_NOP6  = 3'd6,
      CMD_NOP7  = 3'd7
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_EMPTY = 3'd1,
      ST_FULL  = 3'd2,
      ST_ABSENT = 3'd3,
      ST_DUP   = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CSR_NORM = 2'd0,
      CSR_LAT  = 2'd1,
      CSR_MIN  = 2'd2
   } csr_idx_type;

   // one decoded command waiting for the back end
   typedef struct packed {
      cmd_type          cmd;
      logic [PidW-1:0]  pid;
      logic [VrW-1:0]   vr;
      logic [WgtW-1:0]  wgt;
      logic [NiceW-1:0] nice;
      logic [ElapW-1:0] elapsed;
      logic [WgtW-1:0]  extra;
   } item_type;

   typedef struct packed {
      status_type       status;
      logic [PidW-1:0]  pid;
      logic [VrW-1:0]   vr;
      logic [WgtW-1:0]  wgt;
      logic [63:0]      value;
      logic [SumW-1:0]  sum;
   } result_type;

   typedef enum logic [2:0] {
      BE_IDLE, BE_SCAN, BE_DIV, BE_APPLY
   } be_state_type;

endpackage

// ===== rtl/fair_share_run_queue.sv =====
// ----------------------------------------------------------------------------
// fair_share_run_queue: fair share scheduler run queue
// Top level: configuration registers, front end FIFO and back end executor.
// ----------------------------------------------------------------------------
// One command per transaction, one response per command, in order. An
// accepted request waits in the two-entry command FIFO; the back end then
// picks it up, runs a slot scan for enqueue, dequeue, pick_next and tick
// (every slot read in turn, one a cycle, through a registered read stage)
// that the other commands skip, runs the serial 64-bit divider for tick and
// timeslice, and then updates the slot table and loads the response register.
// The last step waits while an earlier response is still untaken, so response
// stalls hold the back end and then fill the command FIFO.
// ----------------------------------------------------------------------------
module fair_share_run_queue (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // cmd[2:0] task_id[18:3] task_vruntime[82:19] task_weight[102:83]
   // nice_value[108:103] run_time[140:109] extra_weight[160:141], zero pad
   input  logic [167:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[2:0] out_task_id[18:3] out_vruntime[82:19] out_weight[102:83]
   // computed_value[166:103] queued_weight[192:167], zero pad
   output logic [199:0] rsp_tdata,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   logic [fsrq_pkg::NormW-1:0] norm_ff;
   logic [fsrq_pkg::LatW-1:0]  lat_ff, min_ff;
   logic                       item_valid, item_take;
   fsrq_pkg::item_type         item;
   fsrq_pkg::result_type       res;

   always_ff @(posedge clock) begin
      if (reset) begin
         norm_ff <= 16'd1024;
         lat_ff  <= 32'd6000000;
         min_ff  <= 32'd750000;
      end else if (csr_we) begin
         unique case (csr_index)
            fsrq_pkg::CSR_NORM: norm_ff <= csr_wdata[15:0];
            fsrq_pkg::CSR_LAT:  lat_ff  <= csr_wdata;
            fsrq_pkg::CSR_MIN:  min_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // front end unpacks all fields below the zero pad
   fsrq_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata[160:0]),
      .item_valid (item_valid),
      .item_take  (item_take),
      .item       (item)
   );

   fsrq_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_take  (item_take),
      .item       (item),
      .norm       (norm_ff),
      .latency    (lat_ff),
      .min_gran   (min_ff),
      .rsp_valid  (rsp_tvalid),
      .rsp_take   (rsp_tready),
      .rsp        (res)
   );

   assign rsp_tdata = {7'd0, res.sum, res.value, res.wgt, res.vr, res.pid, res.status};

endmodule

// ===== rtl/fsrq_front.sv =====
// ----------------------------------------------------------------------------
// fsrq_front: input stage and command queue
// Accepts request transactions, unpacks them and holds them in a small FIFO.
// ----------------------------------------------------------------------------
module fsrq_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [160:0]         req_tdata,
   output logic                 item_valid,
   input  logic                 item_take,
   output fsrq_pkg::item_type   item
);

   fsrq_pkg::item_type mem [fsrq_pkg::FifoDepth];
   logic [0:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   fsrq_pkg::item_type new_item;
   logic push, pop;

   always_comb begin
      new_item.cmd     = fsrq_pkg::cmd_type'(req_tdata[2:0]);
      new_item.pid     = req_tdata[18:3];
      new_item.vr      = req_tdata[82:19];
      new_item.wgt     = req_tdata[102:83];
      new_item.nice    = req_tdata[108:103];
      new_item.elapsed = req_tdata[140:109];
      new_item.extra   = req_tdata[160:141];
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign item_valid = (count_ff != 2'd0);
   assign pop        = item_valid && item_take;
   assign item       = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// ===== rtl/fsrq_divider.sv =====
// ----------------------------------------------------------------------------
// fsrq_divider: serial 64 by 32 bit unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fsrq_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);

   logic [63:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] dsr_ff, dsr_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [32:0] trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done    = 1'b0;
      trial   = {rem_ff[31:0], quo_ff[63]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = trial - {1'b0, dsr_ff};
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done    = 1'b1;
         end
      end
   end

   assign quotient = quo_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

endmodule

// ===== rtl/fsrq_back.sv =====
// ----------------------------------------------------------------------------
// fsrq_back: command execution
// Slot table, serial scan, arithmetic and result register.
// ----------------------------------------------------------------------------
module fsrq_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        item_valid,
   output logic                        item_take,
   input  fsrq_pkg::item_type          item,
   input  logic [fsrq_pkg::NormW-1:0]  norm,
   input  logic [fsrq_pkg::LatW-1:0]   latency,
   input  logic [fsrq_pkg::LatW-1:0]   min_gran,
   output logic                        rsp_valid,
   input  logic                        rsp_take,
   output fsrq_pkg::result_type        rsp
);

   localparam int N = fsrq_pkg::MaxTasks;
   localparam int SW = fsrq_pkg::SlotW;
   localparam int CW = fsrq_pkg::CntW;

   logic [N-1:0]                   valid_ff, valid_in;
   logic [fsrq_pkg::PidW-1:0]      pid_mem [N];
   logic [fsrq_pkg::VrW-1:0]       vr_mem  [N];
   logic [fsrq_pkg::WgtW-1:0]      wgt_mem [N];
   logic [fsrq_pkg::SumW-1:0]      sum_ff, sum_in;

   fsrq_pkg::be_state_type         state_ff, state_in;
   fsrq_pkg::item_type             cur_ff, cur_in;
   logic [CW-1:0]                  idx_ff, idx_in;
   // scan results
   logic                           hit_ff, hit_in;
   logic [SW-1:0]                  hit_slot_ff, hit_slot_in;
   logic                           free_ff, free_in;
   logic [SW-1:0]                  free_slot_ff, free_slot_in;
   logic                           best_ff, best_in;
   logic [SW-1:0]                  best_slot_ff, best_slot_in;
   logic [fsrq_pkg::VrW-1:0]       best_vr_ff, best_vr_in;
   logic [fsrq_pkg::PidW-1:0]      best_pid_ff, best_pid_in;
   logic [63:0]                    quo_ff, quo_in;
   fsrq_pkg::result_type           res_ff, res_in;
   logic                           rvalid_ff, rvalid_in;

   // registered slot read during scan
   logic                           rd_ok_ff;
   logic [SW-1:0]                  rd_slot_ff;
   logic [fsrq_pkg::PidW-1:0]      rd_pid_ff;
   logic [fsrq_pkg::VrW-1:0]       rd_vr_ff;

   // registered read of the slot being removed
   logic [fsrq_pkg::PidW-1:0]      rm_pid_ff;
   logic [fsrq_pkg::VrW-1:0]       rm_vr_ff;
   logic [fsrq_pkg::WgtW-1:0]      rm_wgt_ff;

   // write port
   logic                           wr_en;
   logic [SW-1:0]                  wr_slot;
   logic [fsrq_pkg::PidW-1:0]      wr_pid;
   logic [fsrq_pkg::VrW-1:0]       wr_vr;
   logic [fsrq_pkg::WgtW-1:0]      wr_wgt;
   logic                           wr_all;

   logic                           div_start, div_done;
   logic [63:0]                    div_num, div_q;
   logic [31:0]                    div_den;
   logic [47:0]                    tick_prod;
   logic [51:0]                    slice_prod;
   logic [fsrq_pkg::WgtW-1:0]      tick_div;
   logic [26:0]                    tot;
   logic [fsrq_pkg::SumW-1:0]      rm_wgt;
   logic [fsrq_pkg::SumW:0]        add_sum;
   logic signed [fsrq_pkg::NiceW-1:0] nice_s;
   logic [63:0]                    nice_w;
   logic                           scan_cmd, div_cmd;
   logic [SW-1:0]                  rm_slot;
   logic                           rd_less;

   fsrq_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_q)
   );

   assign tick_div   = (cur_ff.wgt != '0) ? cur_ff.wgt : {4'd0, norm};
   assign tick_prod  = cur_ff.elapsed * norm;
   assign slice_prod = latency * cur_ff.wgt;
   assign tot        = {1'b0, sum_ff} + {7'd0, cur_ff.extra};
   assign nice_s     = signed'(cur_ff.nice);

   always_comb begin
      if (nice_s >= 6'sd10)       nice_w = {49'd0, norm[15:1]};
      else if (nice_s > -6'sd10)  nice_w = {48'd0, norm};
      else if (nice_s > -6'sd20)  nice_w = {47'd0, norm, 1'b0};
      else                        nice_w = {46'd0, norm, 2'b0};
   end

   assign rd_less = (rd_vr_ff < best_vr_ff) ||
                    ((rd_vr_ff == best_vr_ff) && (rd_pid_ff < best_pid_ff));

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      idx_in       = idx_ff;
      hit_in       = hit_ff;
      hit_slot_in  = hit_slot_ff;
      free_in      = free_ff;
      free_slot_in = free_slot_ff;
      best_in      = best_ff;
      best_slot_in = best_slot_ff;
      best_vr_in   = best_vr_ff;
      best_pid_in  = best_pid_ff;
      quo_in       = quo_ff;
      res_in       = res_ff;
      rvalid_in    = rvalid_ff;
      valid_in     = valid_ff;
      sum_in       = sum_ff;
      item_take    = 1'b0;
      div_start    = 1'b0;
      div_num      = '0;
      div_den      = '0;
      wr_en        = 1'b0;
      wr_all       = 1'b0;
      wr_slot      = '0;
      wr_pid       = cur_ff.pid;
      wr_vr        = cur_ff.vr;
      wr_wgt       = cur_ff.wgt;
      scan_cmd     = (cur_ff.cmd == fsrq_pkg::CMD_ENQ) || (cur_ff.cmd == fsrq_pkg::CMD_DEQ)
                     || (cur_ff.cmd == fsrq_pkg::CMD_PICK) || (cur_ff.cmd == fsrq_pkg::CMD_TICK);
      div_cmd      = (cur_ff.cmd == fsrq_pkg::CMD_TICK) || (cur_ff.cmd == fsrq_pkg::CMD_SLICE);
      rm_slot      = (cur_ff.cmd == fsrq_pkg::CMD_PICK) ? best_slot_ff : hit_slot_ff;
      rm_wgt       = {6'd0, rm_wgt_ff};
      add_sum      = {1'b0, sum_ff} + {7'd0, cur_ff.wgt};

      if (rsp_take) begin
         rvalid_in = 1'b0;
      end

      unique case (state_ff)
         fsrq_pkg::BE_IDLE: begin
            if (item_valid) begin
               item_take = 1'b1;
               cur_in    = item;
               idx_in    = '0;
               hit_in    = 1'b0;
               free_in   = 1'b0;
               best_in   = 1'b0;
               state_in  = fsrq_pkg::BE_SCAN;
            end
         end
         fsrq_pkg::BE_SCAN: begin
            // one slot read per cycle, registered and compared in the cycle after
            if (rd_ok_ff) begin
               if (valid_ff[rd_slot_ff]) begin
                  if (!hit_ff && rd_pid_ff == cur_ff.pid) begin
                     hit_in      = 1'b1;
                     hit_slot_in = rd_slot_ff;
                  end
                  if (!best_ff || rd_less) begin
                     best_in      = 1'b1;
                     best_slot_in = rd_slot_ff;
                     best_vr_in   = rd_vr_ff;
                     best_pid_in  = rd_pid_ff;
                  end
               end else if (!free_ff) begin
                  free_in      = 1'b1;
                  free_slot_in = rd_slot_ff;
               end
            end
            if (!scan_cmd || (idx_ff == CW'(N) && !rd_ok_ff)) begin
               state_in = div_cmd ? fsrq_pkg::BE_DIV : fsrq_pkg::BE_APPLY;
               if (cur_ff.cmd == fsrq_pkg::CMD_TICK) begin
                  div_start = 1'b1;
                  div_num   = {16'd0, tick_prod};
                  div_den   = {12'd0, tick_div};
               end else if (cur_ff.cmd == fsrq_pkg::CMD_SLICE) begin
                  div_start = 1'b1;
                  div_num   = {12'd0, slice_prod};
                  div_den   = (tot == '0) ? 32'd1 : {5'd0, tot};
               end
            end else if (idx_ff != CW'(N)) begin
               idx_in = idx_ff + CW'(1);
            end
         end
         fsrq_pkg::BE_DIV: begin
            if (div_done) begin
               quo_in   = div_q;
               state_in = fsrq_pkg::BE_APPLY;
            end
         end
         fsrq_pkg::BE_APPLY: begin
            // holds while the previous response is still waiting
            if (!rvalid_ff || rsp_take) begin
               res_in        = '0;
               res_in.status = fsrq_pkg::ST_OK;
               unique case (cur_ff.cmd)
                  fsrq_pkg::CMD_ENQ: begin
                     if (hit_ff) begin
                        res_in.status = fsrq_pkg::ST_DUP;
                     end else if (!free_ff) begin
                        res_in.status = fsrq_pkg::ST_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        wr_all  = 1'b1;
                        wr_slot = free_slot_ff;
                        valid_in[free_slot_ff] = 1'b1;
                        sum_in  = add_sum[fsrq_pkg::SumW] ? fsrq_pkg::SumMax
                                                          : add_sum[fsrq_pkg::SumW-1:0];
                        res_in.pid = cur_ff.pid;
                        res_in.vr  = cur_ff.vr;
                        res_in.wgt = cur_ff.wgt;
                     end
                  end
                  fsrq_pkg::CMD_DEQ, fsrq_pkg::CMD_PICK: begin
                     if (cur_ff.cmd == fsrq_pkg::CMD_DEQ && !hit_ff) begin
                        res_in.status = fsrq_pkg::ST_ABSENT;
                     end else if (cur_ff.cmd == fsrq_pkg::CMD_PICK && !best_ff) begin
                        res_in.status = fsrq_pkg::ST_EMPTY;
                     end else begin
                        valid_in[rm_slot] = 1'b0;
                        sum_in     = (rm_wgt > sum_ff) ? '0 : sum_ff - rm_wgt;
                        res_in.pid = rm_pid_ff;
                        res_in.vr  = rm_vr_ff;
                        res_in.wgt = rm_wgt_ff;
                     end
                  end
                  fsrq_pkg::CMD_TICK: begin
                     res_in.pid = cur_ff.pid;
                     res_in.vr  = cur_ff.vr + ((tick_div == '0) ? 64'd0 : quo_ff);
                     if (hit_ff) begin
                        wr_en   = 1'b1;
                        wr_slot = hit_slot_ff;
                        wr_vr   = res_in.vr;
                     end
                  end
                  fsrq_pkg::CMD_SLICE: begin
                     res_in.value = (quo_ff < {32'd0, min_gran}) ? {32'd0, min_gran}
                                                                 : quo_ff;
                  end
                  fsrq_pkg::CMD_NICE: begin
                     res_in.value = nice_w;
                  end
                  default: begin
                  end
               endcase
               res_in.sum = sum_in;
               rvalid_in  = 1'b1;
               state_in   = fsrq_pkg::BE_IDLE;
            end
         end
         default: state_in = fsrq_pkg::BE_IDLE;
      endcase
   end

   assign rsp_valid = rvalid_ff;
   assign rsp       = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= fsrq_pkg::BE_IDLE;
         valid_ff  <= '0;
         sum_ff    <= '0;
         rvalid_ff <= 1'b0;
         rd_ok_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         valid_ff  <= valid_in;
         sum_ff    <= sum_in;
         rvalid_ff <= rvalid_in;
         rd_ok_ff  <= (state_ff == fsrq_pkg::BE_SCAN) && (idx_ff != CW'(N)) && scan_cmd;
      end
      cur_ff       <= cur_in;
      idx_ff       <= idx_in;
      hit_ff       <= hit_in;
      hit_slot_ff  <= hit_slot_in;
      free_ff      <= free_in;
      free_slot_ff <= free_slot_in;
      best_ff      <= best_in;
      best_slot_ff <= best_slot_in;
      best_vr_ff   <= best_vr_in;
      best_pid_ff  <= best_pid_in;
      quo_ff       <= quo_in;
      res_ff       <= res_in;
      rd_slot_ff   <= idx_ff[SW-1:0];
      rd_pid_ff    <= pid_mem[idx_ff[SW-1:0]];
      rd_vr_ff     <= vr_mem[idx_ff[SW-1:0]];
      // removal slot is settled from the last scan cycle on
      rm_pid_ff    <= pid_mem[rm_slot];
      rm_vr_ff     <= vr_mem[rm_slot];
      rm_wgt_ff    <= wgt_mem[rm_slot];
   end

   // slot table
   always_ff @(posedge clock) begin
      if (wr_en) begin
         vr_mem[wr_slot] <= wr_vr;
         if (wr_all) begin
            pid_mem[wr_slot] <= wr_pid;
            wgt_mem[wr_slot] <= wr_wgt;
         end
      end
   end

endmodule
